// ===== sv/assert_macros.svh =====
// Assertion macros shared by the genotype table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/gtss_pkg.sv =====
// Package for the genotype table statistics block: back end states,
// statistic index codes, queue status. No dependencies.
`default_nettype none
package gtss_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEN,
    S_MUL,
    S_DIVINIT,
    S_DIV,
    S_OUT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [3:0] STAT_DOM_SENS   = 4'd0;
  localparam logic [3:0] STAT_DOM_SPEC   = 4'd1;
  localparam logic [3:0] STAT_DOM_C      = 4'd2;
  localparam logic [3:0] STAT_REC_SENS   = 4'd3;
  localparam logic [3:0] STAT_REC_SPEC   = 4'd4;
  localparam logic [3:0] STAT_REC_C      = 4'd5;
  localparam logic [3:0] STAT_ADD01_SENS = 4'd6;
  localparam logic [3:0] STAT_ADD01_SPEC = 4'd7;
  localparam logic [3:0] STAT_ADD02_SENS = 4'd8;
  localparam logic [3:0] STAT_ADD02_SPEC = 4'd9;
  localparam logic [3:0] STAT_ADD12_SENS = 4'd10;
  localparam logic [3:0] STAT_ADD12_SPEC = 4'd11;
  localparam logic [3:0] STAT_ADD_C      = 4'd12;

  localparam int          VALUE_W   = 17;
  localparam logic [16:0] VALUE_MAX = 17'h1FFFF;

endpackage
`default_nettype wire

// ===== sv/gtss_queue.sv =====
// Two-entry queue of count snapshots between front and back.
// Depends on gtss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module gtss_queue #(
  parameter int DW = 102
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic [DW-1:0]          push_data,
  input  wire logic                   pop,
  output logic [DW-1:0]               rd_data,
  output gtss_pkg::q_status_t         status
);
  import gtss_pkg::*;

  logic [DW-1:0] mem [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rd_data      = mem[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  `ASSERT_NEVER(a_push_full, clk, rst_n, push && status.full, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && status.empty, "pop from empty queue")
  `ASSERT_NEVER(a_count_rng, clk, rst_n, count_r == 2'd3, "queue count out of range")

endmodule
`default_nettype wire

// ===== sv/gtss_front.sv =====
// Front end: classifies samples into the 2x3 saturating count table and
// pushes a snapshot on the last sample. Depends on gtss_pkg.
`default_nettype none
module gtss_front #(
  parameter int MAX_SAMPLES = 65536,
  parameter int CW          = 17
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [2:0]           in_genotype,
  input  wire logic [1:0]           in_phenotype_group,
  input  wire logic                 in_last_sample,
  input  wire gtss_pkg::q_status_t  q_status,
  output logic                      busy,
  output logic                      push,
  output logic [6*CW-1:0]           push_data
);
  import gtss_pkg::*;

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

  logic [CW-1:0] cnt_r [6];
  logic [CW-1:0] cnt_nxt [6];
  logic [CW-1:0] snap [6];
  logic          accept, hit, col_ok;
  logic [1:0]    col;
  logic [2:0]    idx;

  assign busy   = q_status.full;
  assign accept = start && !q_status.full;
  assign push   = accept && in_last_sample;

  always_comb begin
    col    = 2'd0;
    col_ok = 1'b1;
    case (in_genotype) inside
      3'd1:       col = 2'd0;
      3'd2, 3'd3: col = 2'd1;
      3'd4:       col = 2'd2;
      default:    col_ok = 1'b0;
    endcase
  end

  assign hit = col_ok && (in_phenotype_group == 2'd1 || in_phenotype_group == 2'd2);
  assign idx = (in_phenotype_group == 2'd2) ? (3'd3 + {1'b0, col}) : {1'b0, col};

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      snap[i] = cnt_r[i];
    end
    if (hit && cnt_r[idx] < CNT_MAX) begin
      snap[idx] = cnt_r[idx] + CW'(1);
    end
    for (int i = 0; i < 6; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (accept) cnt_nxt[i] = in_last_sample ? '0 : snap[i];
      push_data[i*CW +: CW] = snap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) cnt_r[i] <= '0;
    end else begin
      for (int i = 0; i < 6; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/gtss_back.sv =====
// Back end: per snapshot, forms thirteen num/den pairs with one shared
// multiplier and a restoring divider. Depends on gtss_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module gtss_back #(
  parameter int CW            = 17,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [6*CW-1:0]      rd_data,
  input  wire gtss_pkg::q_status_t  q_status,
  output logic                      pop,
  output logic                      out_strobe,
  output logic [3:0]                out_stat_index,
  output logic [16:0]               out_stat_value,
  output logic                      out_stats_valid,
  output logic                      out_last_result
);
  import gtss_pkg::*;

  localparam int MW  = CW + 3;
  localparam int PW  = 2 * MW + 2;
  localparam int QW  = FRACTION_BITS + 2;
  localparam int VW  = (QW > VALUE_W) ? QW : VALUE_W;
  localparam int DCW = $clog2(FRACTION_BITS + 1);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(FRACTION_BITS);

  back_state_t state_r, state_nxt;

  logic [CW-1:0]  c_r [6];
  logic [CW-1:0]  c_in [6];
  logic           ok_r, ok_in;
  logic [3:0]     k_r;
  logic [1:0]     step_r, step_last;
  logic [PW-1:0]  acc_r, d2_r, den_r, den_k, num_c;
  logic [PW-1:0]  r_r;
  logic [PW:0]    r_sh;
  logic [QW-1:0]  q_r, q_rnd;
  logic [VW-1:0]  v_ext;
  logic [16:0]    v_sat;
  logic [DCW-1:0] div_cnt_r;
  logic [MW-1:0]  op_a, op_b;
  logic [2*MW-1:0] prod;
  logic [CW:0]    s01, s02, s12, s34, s35, s45;
  logic [CW+1:0]  n0, n1;
  logic           ld, do_den, do_mul, do_init, do_div, emit;
  logic           out_strobe_r;

  always_comb begin
    for (int i = 0; i < 6; i++) c_in[i] = rd_data[i*CW +: CW];
  end

  assign ok_in = ({1'b0, c_in[0]} + {1'b0, c_in[1]} != '0) &&
                 ({1'b0, c_in[0]} + {1'b0, c_in[2]} != '0) &&
                 ({1'b0, c_in[3]} + {1'b0, c_in[4]} != '0) &&
                 ({1'b0, c_in[3]} + {1'b0, c_in[5]} != '0) &&
                 ({1'b0, c_in[4]} + {1'b0, c_in[5]} != '0) &&
                 ({1'b0, c_in[1]} + {1'b0, c_in[2]} != '0);

  assign s01 = {1'b0, c_r[0]} + {1'b0, c_r[1]};
  assign s02 = {1'b0, c_r[0]} + {1'b0, c_r[2]};
  assign s12 = {1'b0, c_r[1]} + {1'b0, c_r[2]};
  assign s34 = {1'b0, c_r[3]} + {1'b0, c_r[4]};
  assign s35 = {1'b0, c_r[3]} + {1'b0, c_r[5]};
  assign s45 = {1'b0, c_r[4]} + {1'b0, c_r[5]};
  assign n0  = {1'b0, s01} + (CW+2)'(c_r[2]);
  assign n1  = {1'b0, s34} + (CW+2)'(c_r[5]);

  // Operand select: each numerator is a sum of up to three products.
  always_comb begin
    op_a      = MW'(1);
    op_b      = MW'(1);
    step_last = 2'd0;
    if (state_r == S_DEN) begin
      op_a = MW'(n0);
      op_b = MW'(n1);
    end else begin
      unique case (k_r)
        STAT_DOM_SENS:   op_a = MW'(s12);
        STAT_DOM_SPEC:   op_a = MW'(c_r[3]);
        STAT_DOM_C: begin
          step_last = 2'd1;
          op_a = (step_r == 2'd0) ? MW'(s12) : MW'(c_r[3]);
          op_b = (step_r == 2'd0) ? MW'(n1) : MW'(n0);
        end
        STAT_REC_SENS:   op_a = MW'(c_r[2]);
        STAT_REC_SPEC:   op_a = MW'(s34);
        STAT_REC_C: begin
          step_last = 2'd1;
          op_a = (step_r == 2'd0) ? MW'(c_r[2]) : MW'(s34);
          op_b = (step_r == 2'd0) ? MW'(n1) : MW'(n0);
        end
        STAT_ADD01_SENS: op_a = MW'(c_r[1]);
        STAT_ADD01_SPEC: op_a = MW'(c_r[3]);
        STAT_ADD02_SENS: op_a = MW'(c_r[2]);
        STAT_ADD02_SPEC: op_a = MW'(c_r[3]);
        STAT_ADD12_SENS: op_a = MW'(c_r[2]);
        STAT_ADD12_SPEC: op_a = MW'(c_r[4]);
        STAT_ADD_C: begin
          step_last = 2'd2;
          case (step_r)
            2'd0: begin
              op_a = MW'(c_r[5]);
              op_b = MW'(c_r[2]);
            end
            2'd1: begin
              op_a = MW'(c_r[4]);
              op_b = (MW'(c_r[2]) << 1) + MW'(c_r[1]);
            end
            default: begin
              op_a = MW'(c_r[3]);
              op_b = (MW'(c_r[2]) << 1) + (MW'(c_r[1]) << 1) + MW'(c_r[0]);
            end
          endcase
        end
        default: op_a = MW'(1);
      endcase
    end
  end

  assign prod = (2*MW)'(op_a) * (2*MW)'(op_b);

  always_comb begin
    unique case (k_r)
      STAT_DOM_SENS, STAT_REC_SENS:   den_k = PW'(n0);
      STAT_DOM_SPEC, STAT_REC_SPEC:   den_k = PW'(n1);
      STAT_ADD01_SENS:                den_k = PW'(s01);
      STAT_ADD01_SPEC:                den_k = PW'(s34);
      STAT_ADD02_SENS:                den_k = PW'(s02);
      STAT_ADD02_SPEC:                den_k = PW'(s35);
      STAT_ADD12_SENS:                den_k = PW'(s12);
      STAT_ADD12_SPEC:                den_k = PW'(s45);
      default:                        den_k = d2_r;
    endcase
  end

  assign num_c = (acc_r > den_k) ? den_k : acc_r;
  assign r_sh  = {r_r, 1'b0};
  assign q_rnd = (q_r + QW'(1)) >> 1;
  assign v_ext = VW'(q_rnd);
  assign v_sat = (v_ext > VW'(VALUE_MAX)) ? VALUE_MAX : v_ext[16:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (!q_status.empty) state_nxt = S_DEN;
      S_DEN:     state_nxt = S_MUL;
      S_MUL:     if (step_r == step_last) state_nxt = S_DIVINIT;
      S_DIVINIT: state_nxt = S_DIV;
      S_DIV:     if (div_cnt_r == DIV_LAST) state_nxt = S_OUT;
      S_OUT:     state_nxt = (k_r == STAT_ADD_C) ? S_IDLE : S_MUL;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ld      = 1'b0;
    do_den  = 1'b0;
    do_mul  = 1'b0;
    do_init = 1'b0;
    do_div  = 1'b0;
    emit    = 1'b0;
    unique case (state_r)
      S_IDLE:    ld = !q_status.empty;
      S_DEN:     do_den = 1'b1;
      S_MUL:     do_mul = 1'b1;
      S_DIVINIT: do_init = 1'b1;
      S_DIV:     do_div = 1'b1;
      S_OUT:     emit = 1'b1;
      default:   ld = 1'b0;
    endcase
  end

  assign pop = ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      k_r          <= STAT_DOM_SENS;
      step_r       <= 2'd0;
      div_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= emit;
      if (ld) k_r <= STAT_DOM_SENS;
      else if (emit) k_r <= k_r + 4'd1;
      if (do_mul) step_r <= (step_r == step_last) ? 2'd0 : step_r + 2'd1;
      else if (ld) step_r <= 2'd0;
      if (do_init) div_cnt_r <= '0;
      else if (do_div) div_cnt_r <= div_cnt_r + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      for (int i = 0; i < 6; i++) c_r[i] <= c_in[i];
      ok_r <= ok_in;
    end
    if (do_den) d2_r <= PW'(prod) << 1;
    if (do_den || emit) acc_r <= '0;
    else if (do_mul) acc_r <= acc_r + PW'(prod);
    if (do_init) begin
      den_r <= den_k;
      if (num_c == den_k) begin
        r_r <= '0;
        q_r <= QW'(1);
      end else begin
        r_r <= num_c;
        q_r <= '0;
      end
    end else if (do_div) begin
      if (r_sh >= {1'b0, den_r}) begin
        r_r <= PW'(r_sh - {1'b0, den_r});
        q_r <= {q_r[QW-2:0], 1'b1};
      end else begin
        r_r <= PW'(r_sh);
        q_r <= {q_r[QW-2:0], 1'b0};
      end
    end
    if (emit) begin
      out_stat_index  <= k_r;
      out_stat_value  <= ok_r ? v_sat : '0;
      out_stats_valid <= ok_r;
      out_last_result <= (k_r == STAT_ADD_C);
    end
  end

  assign out_strobe = out_strobe_r;

  `ASSERT_CLK(a_strobe_src, clk, rst_n, out_strobe |-> $past(state_r == S_OUT), "stray strobe")
  `ASSERT_CLK(a_inval_zero, clk, rst_n, (out_strobe && !out_stats_valid) |-> (out_stat_value == '0), "invalid stat nonzero")
  `ASSERT_CLK(a_div_cnt, clk, rst_n, (state_r == S_DIV) |-> (div_cnt_r <= DIV_LAST), "divider count overrun")
  `ASSERT_CLK(a_last_idx, clk, rst_n, (out_strobe && out_last_result) |=> (state_r == S_IDLE || state_r == S_DEN), "run did not end")

endmodule
`default_nettype wire

// ===== sv/genotype_table_sens_spec.sv =====
// Top level of the genotype table statistics block: front counters, snapshot
// queue and statistic back end. Depends on gtss_pkg and the gtss_* modules.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  input    | start / busy              | in_genotype, in_phenotype_group, in_last_sample
//  result   | out_strobe (no stall)     | out_stat_index, out_stat_value, out_stats_valid,
//           |                           | out_last_result
//
// A sample is taken on each edge where start is high and busy is low; the count
// table updates on that edge. A last sample pushes a count snapshot into a
// two-entry queue; busy is high only while that queue is full.
// Per snapshot the back end forms a denominator product, then for each of the
// thirteen statistics sums products in the shared multiplier, runs the serial
// divider and emits the result; it pops the next snapshot only after the last
// result. Synchronous reset clears the table, queue and sequencer.
`default_nettype none
module genotype_table_sens_spec #(
  parameter int MAX_SAMPLES   = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_genotype,
  input  wire logic [1:0]  in_phenotype_group,
  input  wire logic        in_last_sample,
  output logic             out_strobe,
  output logic [3:0]       out_stat_index,
  output logic [16:0]      out_stat_value,
  output logic             out_stats_valid,
  output logic             out_last_result
);
  import gtss_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  q_status_t        q_status;
  logic             push, pop;
  logic [6*CW-1:0]  push_data, rd_data;

  gtss_front #(.MAX_SAMPLES(MAX_SAMPLES), .CW(CW)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start),
    .in_genotype(in_genotype), .in_phenotype_group(in_phenotype_group),
    .in_last_sample(in_last_sample), .q_status(q_status),
    .busy(busy), .push(push), .push_data(push_data)
  );

  gtss_queue #(.DW(6*CW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .rd_data(rd_data), .status(q_status)
  );

  gtss_back #(.CW(CW), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .rd_data(rd_data), .q_status(q_status),
    .pop(pop), .out_strobe(out_strobe), .out_stat_index(out_stat_index),
    .out_stat_value(out_stat_value), .out_stats_valid(out_stats_valid),
    .out_last_result(out_last_result)
  );

endmodule
`default_nettype wire
